// File: hdl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types and codes of the multiset bag table: request and result
// items, request and status codes, configuration map.
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

    // Default depth of the entry store
    localparam int MAX_ENTRIES_DEF = 16;

    // Request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_COUNT  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Configuration map: one 32-bit register, word aligned
    localparam int         PADDR_W          = 3;
    localparam int         PDATA_W          = 32;
    localparam logic [0:0] CFG_IDX_CAPACITY = 1'b0;
    localparam logic [4:0] CAP_RESET        = 5'd16;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] match_count;
        logic [4:0] fill_level;
    } t_resp;

endpackage : mbt_pkg

`default_nettype wire

// File: hdl/mbt_ram.sv
// ----------------------------------------------------------------------------
// mbt_ram
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_ram
    import mbt_pkg::*;
#(
    parameter int DEPTH = MAX_ENTRIES_DEF,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [31:0]   i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [31:0]   o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : mbt_ram

`default_nettype wire

// File: hdl/mbt_seq.sv
// ----------------------------------------------------------------------------
// mbt_seq
// Request sequencer: holds the fill level, scans the entry store one entry
// a cycle and moves the last entry into the hole on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_seq
    import mbt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int AW          = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [4:0]    i_capacity,
    input  wire logic          i_req_valid,
    input  wire t_req          i_req,
    output logic               o_idle,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output t_resp              o_res,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [31:0]        o_wr_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  wire logic [31:0]   i_rd_data
);

    localparam int FW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (FW > 5) ? FW : 5;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_MOVE_RD = 3'd2;
    localparam logic [2:0] S_MOVE_WR = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    t_req          r_req, n_req;
    logic [FW-1:0] r_issue, n_issue;
    logic          r_cmp_vld, n_cmp_vld;
    logic [AW-1:0] r_cmp_idx, n_cmp_idx;
    logic [FW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_pos, n_pos;
    t_resp         r_res, n_res;

    logic [FW-1:0] last_idx;
    logic          cmp_last;
    logic          match;
    logic          is_full;
    logic          scan_rd;
    logic [FW-1:0] cnt_inc;

    function automatic logic [4:0] low5(input logic [FW-1:0] x);
        logic [CW-1:0] e;
        e = CW'(x);
        return e[4:0];
    endfunction

    assign last_idx = r_fill - FW'(1);
    assign cmp_last = (FW'(r_cmp_idx) == last_idx);
    assign match    = (i_rd_data == r_req.value);
    assign cnt_inc  = r_cnt + FW'(match);
    assign is_full  = (r_fill == FW'(MAX_ENTRIES)) || (CW'(r_fill) >= CW'(i_capacity));
    assign scan_rd  = (r_state == S_SCAN) && (r_issue < r_fill);

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    // Read port: scan addresses, or the last entry ahead of a move
    assign o_rd_en   = scan_rd || (r_state == S_MOVE_RD);
    assign o_rd_addr = (r_state == S_MOVE_RD) ? last_idx[AW-1:0] : r_issue[AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_req     = r_req;
        n_issue   = r_issue;
        n_cmp_vld = scan_rd;
        n_cmp_idx = r_issue[AW-1:0];
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_res     = r_res;
        o_wr_en   = 1'b0;
        o_wr_addr = r_fill[AW-1:0];
        o_wr_data = i_req.value;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_issue = '0;
                    n_cnt   = '0;
                    n_res   = '{status: ST_OK, match_count: 5'd0, fill_level: low5(r_fill)};
                    n_state = S_DONE;
                    case (i_req.req_type)
                        REQ_INSERT: begin
                            if (is_full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_wr_en          = 1'b1;
                                n_fill           = r_fill + FW'(1);
                                n_res.fill_level = low5(r_fill + FW'(1));
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_fill == '0) begin
                                n_res.status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        REQ_COUNT: begin
                            if (r_fill != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_rd) begin
                    n_issue = r_issue + FW'(1);
                end
                if (r_cmp_vld) begin
                    if (r_req.req_type == REQ_COUNT) begin
                        n_cnt = cnt_inc;
                        if (cmp_last) begin
                            n_res.match_count = low5(cnt_inc);
                            n_state           = S_DONE;
                        end
                    end else if (match) begin
                        n_pos   = r_cmp_idx;
                        n_state = S_MOVE_RD;
                    end else if (cmp_last) begin
                        n_res.status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end
                end
            end
            S_MOVE_RD: begin
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                o_wr_en          = 1'b1;
                o_wr_addr        = r_pos;
                o_wr_data        = i_rd_data;
                n_fill           = last_idx;
                n_res.fill_level = low5(last_idx);
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_issue   <= n_issue;
        r_cmp_idx <= n_cmp_idx;
        r_cnt     <= n_cnt;
        r_pos     <= n_pos;
        r_res     <= n_res;
    end

endmodule : mbt_seq

`default_nettype wire

// File: hdl/multiset_bag_table_unit.sv
// Latency: insert, unknown requests and requests on an empty bag go to the result with no scan;
// count and a missed remove scan every stored entry, a remove that hits also moves the last entry.
// Throughput: one item in flight, one store read a cycle; the next item is accepted the cycle
// after the result moves to the output register.
// Reset: fill level 0, capacity 16, output register empty, no item accepted; entry store is
// not cleared, only entries below the fill level are ever read.
// ----------------------------------------------------------------------------
// multiset_bag_table_unit
// Bag of signed 32-bit values with insert, remove and count requests,
// kept in a synchronous entry store with an APB-style capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module multiset_bag_table_unit
    import mbt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_req               i_in_data,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_resp                   o_out_data,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // Store address width; keep one bit for a single-entry store
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [4:0]    r_cap;
    logic          r_out_vld;
    t_resp         r_out;

    logic          seq_idle;
    logic          res_valid;
    logic          res_ready;
    t_resp         res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          cfg_wr;
    logic          cfg_hit;

    // ------------------------------------------------------------------
    // Configuration: capacity register, written on the access phase
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[PADDR_W-1:2] == CFG_IDX_CAPACITY);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? {{(PDATA_W-5){1'b0}}, r_cap} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[4:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and entry store. Accept a new item only while the
    // sequencer is idle and out of reset; every store access of one item
    // is finished before the next item starts, so no forwarding is needed.
    // ------------------------------------------------------------------
    assign o_in_ready = seq_idle && i_rst_n;

    mbt_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_cap),
        .i_req_valid (i_in_valid),
        .i_req       (i_in_data),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    mbt_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Output register: hold a finished item until the consumer takes it,
    // so the sequencer can go back to idle and accept the next item.
    // ------------------------------------------------------------------
    assign res_ready = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A pending result means the sequencer is not idle
    a_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !o_in_ready)
        else $error("request ready while a result is pending");

    // An accepted item occupies the sequencer in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer idle right after accepting an item");

    // Only count requests report matches; this checks that failed requests report none
    a_status_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && (res.status == ST_FULL || res.status == ST_NOT_FOUND))
            |-> (res.match_count == 5'd0))
        else $error("match count on a failed request");
`endif

endmodule : multiset_bag_table_unit

`default_nettype wire
